// ----- src/cidrpm_pkg.sv -----
`default_nettype none

package cidrpm_pkg;

  localparam int unsigned HeaderLen = 11;
  localparam int unsigned OctetMax  = 255;
  localparam int unsigned PrefixMax = 32;

  localparam logic [7:0] ChBar  = 8'h7C;
  localparam logic [7:0] ChDot  = 8'h2E;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  // which field of the rule text is being read
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_HOST   = 2'd1,
    PH_NET    = 2'd2,
    PH_PREFIX = 2'd3
  } phase_e;

  // parse state captured on the last byte of a rule
  typedef struct packed {
    logic        ok;
    logic [31:0] host;
    logic [31:0] net;
    logic [7:0]  prefix;
  } snap_t;

  // result of one rule
  typedef struct packed {
    logic        status;
    logic [31:0] host;
    logic [31:0] net;
    logic [5:0]  prefix;
    logic        match;
  } res_t;

  // fixed header text, one character per position
  function automatic logic [7:0] header_char(logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h49; // I
      4'd1:    ch = 8'h50; // P
      4'd2:    ch = 8'h5F; // _
      4'd3:    ch = 8'h49; // I
      4'd4:    ch = 8'h4E; // N
      4'd5:    ch = 8'h5F; // _
      4'd6:    ch = 8'h43; // C
      4'd7:    ch = 8'h49; // I
      4'd8:    ch = 8'h44; // D
      4'd9:    ch = 8'h52; // R
      4'd10:   ch = ChBar;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- src/cidr_rule_text_parse_match.sv -----
// cidr rule parser: takes a rule text (a fixed eleven-character header ending in a bar,
// then host|network|prefix) one byte per transfer on the slave stream and, for the byte
// marked tlast, gives one result transfer on the master stream. one byte is taken every
// cycle while the slave side is ready; the parse state is a single register stage
// updated from each byte, the last byte's state is captured in a snapshot register,
// and the mask check fills the output register, so a result passes through the
// snapshot and then the output register. the slave side stalls only while both the
// snapshot and the output register hold results that the master side has not taken.
// the next rule may start in the cycle after a last byte. status is 0 for a valid rule;
// an invalid rule gives status 1 with all data fields zero.
`default_nettype none

module cidr_rule_text_parse_match (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,   // is_last
  // master stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // [31:0] host_addr, [63:32] net_addr,
                                             // [69:64] prefix_len, [70] is_match, [71] zero
  output logic             m_axis_tuser_o    // status_code
);

  // parse state
  cidrpm_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic        err_q, err_d;
  logic [7:0]  acc_q, acc_d;
  logic [1:0]  len_q, len_d;
  logic        lead_q, lead_d;
  logic [1:0]  oct_q, oct_d;
  logic [31:0] host_q, host_d;
  logic [31:0] net_q, net_d;

  // next parse state before the end-of-rule clear
  cidrpm_pkg::phase_e phase_nx;
  logic [3:0]  hdr_pos_nx;
  logic        err_nx;
  logic [7:0]  acc_nx;
  logic [1:0]  len_nx;
  logic        lead_nx;
  logic [1:0]  oct_nx;
  logic [31:0] host_nx;
  logic [31:0] net_nx;

  // snapshot and output stages
  logic               snap_valid_q, snap_valid_d;
  cidrpm_pkg::snap_t  snap_q, snap_d;
  logic               out_valid_q, out_valid_d;
  cidrpm_pkg::res_t   res_q, res_d;
  cidrpm_pkg::res_t   fin_res;

  logic        in_fire;
  logic        out_free;
  logic        snap_adv;
  logic [7:0]  ch;
  logic        is_digit;
  logic [3:0]  dig;
  logic [11:0] dig_val;
  logic [11:0] limit;
  logic        dig_err;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign snap_adv        = !snap_valid_q || out_free;
  assign s_axis_tready_o = snap_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign ch       = s_axis_tdata_i;
  assign is_digit = (ch >= cidrpm_pkg::ChZero) && (ch <= cidrpm_pkg::ChNine);
  assign dig      = ch[3:0];
  // value after taking the digit: acc * 10 + d, by shifts
  assign dig_val  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {8'd0, dig};
  assign limit    = (phase_q == cidrpm_pkg::PH_PREFIX) ? 12'(cidrpm_pkg::PrefixMax)
                                                       : 12'(cidrpm_pkg::OctetMax);
  // a second digit after a leading zero, or a value over the field's limit
  assign dig_err  = ((len_q != 2'd0) && lead_q) || (dig_val > limit);

  // per-byte parse step
  always_comb begin
    phase_nx   = phase_q;
    hdr_pos_nx = hdr_pos_q;
    err_nx     = err_q;
    acc_nx     = acc_q;
    len_nx     = len_q;
    lead_nx    = lead_q;
    oct_nx     = oct_q;
    host_nx    = host_q;
    net_nx     = net_q;

    // once in error, bytes pass without effect until the last one
    if (!err_q) begin
      unique case (phase_q)
        cidrpm_pkg::PH_HEADER: begin
          if (hdr_pos_q >= 4'(cidrpm_pkg::HeaderLen) ||
              ch != cidrpm_pkg::header_char(hdr_pos_q)) begin
            err_nx = 1'b1;
          end else begin
            hdr_pos_nx = hdr_pos_q + 4'd1;
            if (hdr_pos_q == 4'(cidrpm_pkg::HeaderLen - 1)) begin
              phase_nx = cidrpm_pkg::PH_HOST;
            end
          end
        end
        default: begin
          if (is_digit) begin
            if (dig_err) begin
              err_nx = 1'b1;
            end else begin
              acc_nx = dig_val[7:0];
              if (len_q == 2'd0 && dig == 4'd0) begin
                lead_nx = 1'b1;
              end
              if (len_q != 2'd2) begin
                len_nx = len_q + 2'd1;
              end
            end
          end else if (phase_q == cidrpm_pkg::PH_PREFIX) begin
            // only digits may follow the last bar
            err_nx = 1'b1;
          end else if (ch == cidrpm_pkg::ChDot) begin
            if (len_q == 2'd0 || oct_q == 2'd3) begin
              err_nx = 1'b1;
            end else begin
              if (phase_q == cidrpm_pkg::PH_HOST) begin
                host_nx = {host_q[23:0], acc_q};
              end else begin
                net_nx = {net_q[23:0], acc_q};
              end
              acc_nx  = 8'd0;
              len_nx  = 2'd0;
              lead_nx = 1'b0;
              oct_nx  = oct_q + 2'd1;
            end
          end else if (ch == cidrpm_pkg::ChBar) begin
            if (len_q == 2'd0 || oct_q != 2'd3) begin
              err_nx = 1'b1;
            end else begin
              if (phase_q == cidrpm_pkg::PH_HOST) begin
                host_nx  = {host_q[23:0], acc_q};
                phase_nx = cidrpm_pkg::PH_NET;
              end else begin
                net_nx   = {net_q[23:0], acc_q};
                phase_nx = cidrpm_pkg::PH_PREFIX;
              end
              acc_nx  = 8'd0;
              len_nx  = 2'd0;
              lead_nx = 1'b0;
              oct_nx  = 2'd0;
            end
          end else begin
            // stray character, nul included
            err_nx = 1'b1;
          end
        end
      endcase
    end
  end

  // state register update, snapshot capture and output stage
  always_comb begin
    phase_d   = phase_q;
    hdr_pos_d = hdr_pos_q;
    err_d     = err_q;
    acc_d     = acc_q;
    len_d     = len_q;
    lead_d    = lead_q;
    oct_d     = oct_q;
    host_d    = host_q;
    net_d     = net_q;

    snap_valid_d = snap_valid_q;
    snap_d       = snap_q;
    out_valid_d  = out_valid_q;
    res_d        = res_q;

    if (in_fire) begin
      if (s_axis_tlast_i) begin
        // rule ends here: everything returns to its reset value
        phase_d   = cidrpm_pkg::PH_HEADER;
        hdr_pos_d = 4'd0;
        err_d     = 1'b0;
        acc_d     = 8'd0;
        len_d     = 2'd0;
        lead_d    = 1'b0;
        oct_d     = 2'd0;
        host_d    = 32'd0;
        net_d     = 32'd0;
      end else begin
        phase_d   = phase_nx;
        hdr_pos_d = hdr_pos_nx;
        err_d     = err_nx;
        acc_d     = acc_nx;
        len_d     = len_nx;
        lead_d    = lead_nx;
        oct_d     = oct_nx;
        host_d    = host_nx;
        net_d     = net_nx;
      end
    end

    if (snap_adv) begin
      snap_valid_d = in_fire && s_axis_tlast_i;
      snap_d.ok    = !err_nx && (phase_nx == cidrpm_pkg::PH_PREFIX) && (len_nx != 2'd0);
      snap_d.host  = host_nx;
      snap_d.net   = net_nx;
      snap_d.prefix = acc_nx;
    end

    if (out_free) begin
      out_valid_d = snap_valid_q;
      res_d       = fin_res;
    end
  end

  cidrpm_finish u_finish (
    .snap_i (snap_q),
    .res_o  (fin_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cidrpm_pkg::PH_HEADER;
      hdr_pos_q    <= 4'd0;
      err_q        <= 1'b0;
      acc_q        <= 8'd0;
      len_q        <= 2'd0;
      lead_q       <= 1'b0;
      oct_q        <= 2'd0;
      host_q       <= 32'd0;
      net_q        <= 32'd0;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      hdr_pos_q    <= hdr_pos_d;
      err_q        <= err_d;
      acc_q        <= acc_d;
      len_q        <= len_d;
      lead_q       <= lead_d;
      oct_q        <= oct_d;
      host_q       <= host_d;
      net_q        <= net_d;
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    res_q  <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.status;
  assign m_axis_tdata_o  = {1'b0, res_q.match, res_q.prefix, res_q.net, res_q.host};

  // a valid result never carries a prefix over 32
  a_prefix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[69:64] <= 6'd32))
    else $error("valid result with prefix over 32");

  // an invalid rule gives all data fields zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 72'd0))
    else $error("error result with non-zero data");

  // an empty component holds no value and no leading-zero mark
  a_empty_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == 2'd0) |-> (acc_q == 8'd0 && !lead_q))
    else $error("empty component with stale value");

  // the header phase has no octets collected yet
  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cidrpm_pkg::PH_HEADER) |-> (oct_q == 2'd0 && host_q == 32'd0))
    else $error("octet state outside address fields");

endmodule

`default_nettype wire

// ----- src/cidrpm_finish.sv -----
`default_nettype none

// prefix mask, network canonical check and host match
module cidrpm_finish (
  input  cidrpm_pkg::snap_t snap_i,
  output cidrpm_pkg::res_t  res_o
);

  logic [31:0] mask;
  logic [5:0]  shamt;
  logic        prefix_ok;
  logic        ok;

  always_comb begin
    prefix_ok = snap_i.prefix <= 8'(cidrpm_pkg::PrefixMax);
    shamt     = 6'(cidrpm_pkg::PrefixMax) - snap_i.prefix[5:0];
    if (!prefix_ok || snap_i.prefix == 8'd0) begin
      mask = 32'd0;
    end else begin
      mask = 32'hFFFF_FFFF << shamt;
    end
    ok = snap_i.ok && prefix_ok && ((snap_i.net & ~mask) == 32'd0);

    if (ok) begin
      res_o.status = 1'b0;
      res_o.host   = snap_i.host;
      res_o.net    = snap_i.net;
      res_o.prefix = snap_i.prefix[5:0];
      res_o.match  = (snap_i.host & mask) == snap_i.net;
    end else begin
      res_o.status = 1'b1;
      res_o.host   = 32'd0;
      res_o.net    = 32'd0;
      res_o.prefix = 6'd0;
      res_o.match  = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/cidr_rule_text_parse_match_tb.sv -----
module cidr_rule_text_parse_match_tb;

  // expectation of a table row: typed in, or left to the rule predictor
  typedef struct packed {
    logic             known;
    cidrpm_pkg::res_t res;
  } row_want_t;

  localparam int unsigned NUM_DIR      = 26;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned IDLE_PCT     = 35;
  localparam logic [7:0]  NUL_MARK     = 8'h23;  // '#' in a table row stands for a NUL byte
  localparam logic [7:0]  HDR_MARK     = 8'h40;  // '@' in a table row stands for the header

  localparam row_want_t PREDICT  = '0;
  localparam row_want_t REJECT   = '{known: 1'b1,
                                     res: '{status: 1'b1, host: '0, net: '0, prefix: '0,
                                            match: 1'b0}};
  localparam row_want_t ALL_ONES = '{known: 1'b1,
                                     res: '{status: 1'b0, host: 32'hFFFF_FFFF,
                                            net: 32'hFFFF_FFFF, prefix: 6'd32, match: 1'b1}};
  localparam row_want_t ALL_ZERO = '{known: 1'b1,
                                     res: '{status: 1'b0, host: '0, net: '0, prefix: '0,
                                            match: 1'b1}};

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] in_byte
  logic        s_axis_tlast_i  = 1'b0; // is_last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;         // [31:0] host, [63:32] net, [69:64] prefix, [70] match
  logic        m_axis_tuser_o;         // status_code

  cidr_rule_text_parse_match u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // directed rules: every special case once, extremes typed in by hand
  string dir_text [NUM_DIR] = '{
    "@192.168.1.10|192.168.1.0|24",
    "@255.255.255.255|255.255.255.255|32",
    "@0.0.0.0|0.0.0.0|0",
    "@10.20.30.40|0.0.0.0|0",
    "@172.31.5.4|172.16.0.0|12",
    "@200.1.1.1|128.0.0.0|1",
    "@10.1.3.3|10.1.2.0|24",
    "@9.8.7.7|9.8.7.6|31",
    "@10.1.2.3|10.1.2.1|24",
    "IP_IN_CIDX|1.2.3.4|1.2.3.4|32",
    "@01.2.3.4|1.2.3.4|32",
    "@1.2.3.256|1.2.3.0|24",
    "@1.2.3.4.5|1.2.3.4|32",
    "@1.2.3|1.2.3.0|24",
    "@1..3.4|1.2.3.4|32",
    "@1.2.3.4|1.2.3.4|32|",
    "@1.2.3.4|0.0.0.0|33",
    "@1.2.3.4|1.2.3.4|032",
    "@1.2.3.4|1.2.3.0|",
    "@1.2.3.4",
    "@1.2.3.4|1.2",
    "IP_IN_CID",
    "@1.2#.3.4|1.2.3.4|32",
    "@1x2.3.4|garbage after the error|",
    "|",
    "@1.2.3.4|1.2.3.4|3.2"
  };

  row_want_t dir_want [NUM_DIR] = '{
    PREDICT, ALL_ONES, ALL_ZERO, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT,
    REJECT,  REJECT,   REJECT,   REJECT,  REJECT,  REJECT,  REJECT,  REJECT,
    REJECT,  REJECT,   REJECT,   REJECT,  REJECT,  REJECT,  REJECT,  REJECT,
    REJECT,  REJECT
  };

  // rule predictor state
  string               rule_header;
  cidrpm_pkg::phase_e  field_now;
  int unsigned         hdr_seen;
  bit                  rule_broken;
  logic [7:0]          num_val;
  int unsigned         num_digits;
  bit                  num_lead_zero;
  int unsigned         octets_done;
  logic [31:0]         host_word;
  logic [31:0]         net_word;

  cidrpm_pkg::res_t verdict_q [$];   // verdicts of rules whose last byte has gone in
  logic [7:0]   rule_buf [$];    // bytes of the rule being sent
  int unsigned  mismatch_count = 0;
  int unsigned  results_seen   = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  hold_left      = 0;
  bit           hold_request   = 1'b0;
  bit           no_idle        = 1'b0;

  function automatic void clear_number();
    num_val       = '0;
    num_digits    = 0;
    num_lead_zero = 1'b0;
  endfunction

  function automatic void clear_parser();
    field_now   = cidrpm_pkg::PH_HEADER;
    hdr_seen    = 0;
    rule_broken = 1'b0;
    octets_done = 0;
    host_word   = '0;
    net_word    = '0;
    clear_number();
  endfunction

  function automatic void add_digit(int unsigned d, int unsigned limit);
    // a second digit after a leading zero, or overflow past the limit
    if (num_digits != 0 && num_lead_zero) begin
      rule_broken = 1'b1;
      return;
    end
    if (num_val > (limit - d) / 10) begin
      rule_broken = 1'b1;
      return;
    end
    if (num_digits == 0 && d == 0) num_lead_zero = 1'b1;
    num_val = 8'(num_val * 10 + d);
    if (num_digits < 2) num_digits++;
  endfunction

  function automatic void store_octet();
    if (field_now == cidrpm_pkg::PH_HOST) host_word = {host_word[23:0], num_val};
    else net_word = {net_word[23:0], num_val};
    clear_number();
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= cidrpm_pkg::ChZero) && (c <= cidrpm_pkg::ChNine);
    if (rule_broken) return;
    case (field_now)
      cidrpm_pkg::PH_HEADER: begin
        if (hdr_seen >= cidrpm_pkg::HeaderLen || c != 8'(rule_header[hdr_seen])) begin
          rule_broken = 1'b1;
        end else begin
          hdr_seen++;
          if (hdr_seen == cidrpm_pkg::HeaderLen) field_now = cidrpm_pkg::PH_HOST;
        end
      end
      cidrpm_pkg::PH_PREFIX: begin
        if (is_digit) add_digit(int'(c - cidrpm_pkg::ChZero), cidrpm_pkg::PrefixMax);
        else rule_broken = 1'b1;
      end
      default: begin
        if (is_digit) begin
          add_digit(int'(c - cidrpm_pkg::ChZero), cidrpm_pkg::OctetMax);
        end else if (c == cidrpm_pkg::ChDot) begin
          if (num_digits == 0 || octets_done >= 3) begin
            rule_broken = 1'b1;
          end else begin
            store_octet();
            octets_done++;
          end
        end else if (c == cidrpm_pkg::ChBar) begin
          if (num_digits == 0 || octets_done != 3) begin
            rule_broken = 1'b1;
          end else begin
            store_octet();
            octets_done = 0;
            field_now   = (field_now == cidrpm_pkg::PH_HOST) ? cidrpm_pkg::PH_NET
                                                             : cidrpm_pkg::PH_PREFIX;
          end
        end else begin
          rule_broken = 1'b1;
        end
      end
    endcase
  endfunction

  // verdict on the last byte, then back to the header state
  function automatic cidrpm_pkg::res_t close_rule();
    cidrpm_pkg::res_t r;
    logic [31:0]      mask;
    logic             ok;
    r    = '0;
    mask = '0;
    ok   = !rule_broken && field_now == cidrpm_pkg::PH_PREFIX && num_digits != 0 &&
           num_val <= cidrpm_pkg::PrefixMax;
    if (ok && num_val != 0) mask = 32'hFFFF_FFFF << (cidrpm_pkg::PrefixMax - num_val);
    if (ok && (net_word & mask) != net_word) ok = 1'b0;
    if (ok) begin
      r.host   = host_word;
      r.net    = net_word;
      r.prefix = num_val[5:0];
      r.match  = (host_word & mask) == net_word;
    end else begin
      r.status = 1'b1;
    end
    clear_parser();
    return r;
  endfunction

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly characters the parser cares about, now and then any byte
  function automatic logic [7:0] text_char();
    case ($urandom_range(4))
      0, 1:    return cidrpm_pkg::ChZero + 8'($urandom_range(9));
      2:       return cidrpm_pkg::ChDot;
      3:       return cidrpm_pkg::ChBar;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic string quad_text(logic [31:0] a);
    return $sformatf("%0d.%0d.%0d.%0d", a[31:24], a[23:16], a[15:8], a[7:0]);
  endfunction

  function automatic void load_text(string s, bit marks);
    rule_buf.delete();
    for (int i = 0; i < s.len(); i++) begin
      if (marks && 8'(s[i]) == HDR_MARK) begin
        for (int j = 0; j < rule_header.len(); j++) rule_buf.push_back(8'(rule_header[j]));
      end else begin
        rule_buf.push_back((marks && 8'(s[i]) == NUL_MARK) ? 8'h00 : 8'(s[i]));
      end
    end
  endfunction

  task automatic build_random_rule();
    logic [31:0] host;
    logic [31:0] net;
    logic [31:0] mask;
    int unsigned plen;
    int unsigned kind;
    int unsigned pos;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind < 72) begin
      // well-formed rule with random content, a fifth of them then damaged
      host = {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
      plen = $urandom_range(32);
      mask = (plen == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - plen);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: net = host & mask;
        5, 6, 7, 8:    net = {rand_octet(), rand_octet(), rand_octet(), rand_octet()} & mask;
        default:       net = {rand_octet(), rand_octet(), rand_octet(), rand_octet()};
      endcase
      load_text($sformatf("%s%s|%s|%0d", rule_header, quad_text(host), quad_text(net),
                          plen), 1'b0);
      if (kind >= 58) begin
        pos = $urandom_range(rule_buf.size() - 1);
        case ($urandom_range(3))
          0:       rule_buf[pos] = text_char();
          1:       rule_buf.delete(pos);
          2:       rule_buf.insert(pos, text_char());
          default: while (rule_buf.size() > pos + 1) void'(rule_buf.pop_back());
        endcase
      end
    end else if (kind < 86) begin
      // right header, then a jumble of digits and delimiters
      load_text(rule_header, 1'b0);
      n = $urandom_range(1, 30);
      repeat (n) rule_buf.push_back(text_char());
    end else begin
      rule_buf.delete();
      n = $urandom_range(1, 40);
      repeat (n) rule_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic last, input row_want_t want);
    cidrpm_pkg::res_t verdict;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_char(c);
    if (last) begin
      verdict = close_rule();
      if (want.known) verdict = want.res;
      verdict_q.push_back(verdict);
    end
  endtask

  task automatic send_rule(input row_want_t want);
    for (int i = 0; i < rule_buf.size(); i++) begin
      send_byte(rule_buf[i], i == rule_buf.size() - 1, want);
    end
  endtask

  // sender stops offering until every verdict has been matched
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  task automatic check_result();
    cidrpm_pkg::res_t want;
    results_seen++;
    if (verdict_q.size() == 0) begin
      flag_mismatch("result with no rule pending", m_axis_tdata_o[31:0], 32'h0);
      return;
    end
    want = verdict_q.pop_front();
    if (m_axis_tuser_o !== want.status)
      flag_mismatch("status", 32'(m_axis_tuser_o), 32'(want.status));
    if (m_axis_tdata_o[31:0] !== want.host)
      flag_mismatch("host", m_axis_tdata_o[31:0], want.host);
    if (m_axis_tdata_o[63:32] !== want.net)
      flag_mismatch("network", m_axis_tdata_o[63:32], want.net);
    if (m_axis_tdata_o[69:64] !== want.prefix)
      flag_mismatch("prefix", 32'(m_axis_tdata_o[69:64]), 32'(want.prefix));
    if (m_axis_tdata_o[70] !== want.match)
      flag_mismatch("match", 32'(m_axis_tdata_o[70]), 32'(want.match));
    if (m_axis_tdata_o[71] !== 1'b0)
      flag_mismatch("pad bit", 32'(m_axis_tdata_o[71]), 32'h0);
  endtask

  // result side: check each transfer, then choose the next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) check_result();
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned rule_no;
    int unsigned random_sent;
    // header text taken from the design's own character table
    rule_header = "";
    for (int i = 0; i < cidrpm_pkg::HeaderLen; i++) begin
      rule_header = $sformatf("%s%c", rule_header, cidrpm_pkg::header_char(4'(i)));
    end
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_DIR; r++) begin
      load_text(dir_text[r], 1'b1);
      send_rule(dir_want[r]);
    end
    drain_results();

    rule_no     = 0;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      // a stretch with no idling on either side
      no_idle = (rule_no >= 18 && rule_no < 26);
      // long receiver hold-off while bytes keep coming, so the input stalls
      if (rule_no == 8) hold_request = 1'b1;
      if (rule_no == 16) drain_results();
      build_random_rule();
      random_sent += rule_buf.size();
      send_rule(PREDICT);
      rule_no++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
